/* rtl/frpq_pkg.sv */
// Shared constants and types for the frame receiver with packet queue.
// Used by frame_receiver_with_packet_queue; no dependencies.
package frpq_pkg;

    // Queue geometry
    localparam int SLOTS      = 5;
    localparam int SLOT_BYTES = 64;

    // Frame format
    localparam logic [7:0] SYNC0      = 8'hAA;
    localparam logic [7:0] SYNC1      = 8'h5A;
    localparam int         HEADER_LEN = 12;
    localparam int         LEN_INDEX  = 11;

    // Derived widths
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int ASM_AW   = $clog2(SLOT_BYTES);
    localparam int IDX_W    = $clog2(SLOT_BYTES + 1);
    localparam int STORE_D  = SLOTS * SLOT_BYTES;
    localparam int STORE_AW = $clog2(STORE_D);
    localparam int ACNT_W   = 9;    // header plus a 255 byte payload

    // Request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

endpackage

/* rtl/frame_receiver_with_packet_queue.sv */
// Received byte: status result (if the frame completes) in the cycle after the request.
// Stored frame: busy while its L bytes are copied into its slot (L = 12..64).
// Tick: slot selected, then the registered RAM read, then one byte per cycle; busy while the bytes are sent.
// Both copy and send run at one byte a cycle, set by the single RAM read port.
// Reset (synchronous, i_rst_n low) empties the queue and the assembly; RAM contents persist.
// Results cannot be stalled: o_valid marks each for exactly one cycle.
module frame_receiver_with_packet_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    output logic       o_kind,
    output logic [1:0] o_status,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic [2:0] o_frames_queued
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_SEND
    } t_state;

    t_state r_state;

    // Assembly of the incoming frame
    logic [frpq_pkg::ACNT_W-1:0]   r_acnt;      // bytes of current frame so far
    logic [7:0]                    r_len_byte;  // header byte 11

    // Ring of frame slots
    logic [frpq_pkg::SLOT_W-1:0]   r_rd_slot;
    logic [frpq_pkg::SLOT_W-1:0]   r_wr_slot;
    logic [frpq_pkg::CNT_W-1:0]    r_count;
    logic [frpq_pkg::IDX_W-1:0]    r_slot_len [frpq_pkg::SLOTS];

    // Copy / send sequencer, shared by both operations
    logic [frpq_pkg::STORE_AW-1:0] r_base;      // start of the slot in the frame store
    logic [frpq_pkg::IDX_W-1:0]    r_idx;       // next byte to read
    logic [frpq_pkg::IDX_W-1:0]    r_len;       // bytes to move
    logic                          r_p_vld;     // read data arrives this cycle
    logic [frpq_pkg::IDX_W-1:0]    r_p_idx;
    logic                          r_p_last;

    // Status result
    logic                          r_st_vld;
    frpq_pkg::t_status             r_status;

    // Memory ports
    logic                          asm_we;
    logic [7:0]                    asm_rdata;
    logic                          store_we;
    logic [7:0]                    store_rdata;

    logic                          accept;
    logic                          issue;
    logic                          seq_done;
    logic [frpq_pkg::ACNT_W-1:0]   n_acnt;
    logic [7:0]                    len_val;
    logic [frpq_pkg::ACNT_W-1:0]   frame_len;
    logic                          frame_done;
    logic                          in_buffer;
    logic [frpq_pkg::SLOT_W-1:0]   rd_next;
    logic [frpq_pkg::SLOT_W-1:0]   wr_next;
    logic                          send_out;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    // Byte count after this one; length is the arriving byte when it is byte 11.
    assign n_acnt     = r_acnt + frpq_pkg::ACNT_W'(1);
    assign len_val    = (r_acnt == frpq_pkg::ACNT_W'(frpq_pkg::LEN_INDEX)) ? i_rx_byte
                                                                            : r_len_byte;
    assign frame_len  = frpq_pkg::ACNT_W'(frpq_pkg::HEADER_LEN) + frpq_pkg::ACNT_W'(len_val);
    assign in_buffer  = (r_acnt < frpq_pkg::ACNT_W'(frpq_pkg::SLOT_BYTES));
    assign frame_done = (r_acnt >= frpq_pkg::ACNT_W'(2))
                     && (n_acnt >= frpq_pkg::ACNT_W'(frpq_pkg::HEADER_LEN))
                     && (n_acnt == frame_len);

    // Only bytes 0 and 1 are conditional; every later byte within a slot is buffered.
    always_comb begin
        asm_we = 1'b0;
        if (accept && (i_opcode == frpq_pkg::OP_BYTE)) begin
            if (r_acnt == frpq_pkg::ACNT_W'(0)) begin
                asm_we = (i_rx_byte == frpq_pkg::SYNC0);
            end else if (r_acnt == frpq_pkg::ACNT_W'(1)) begin
                asm_we = (i_rx_byte == frpq_pkg::SYNC1);
            end else begin
                asm_we = in_buffer;
            end
        end
    end

    assign rd_next = (r_rd_slot == frpq_pkg::SLOT_W'(frpq_pkg::SLOTS - 1))
                   ? '0 : r_rd_slot + frpq_pkg::SLOT_W'(1);
    assign wr_next = (r_wr_slot == frpq_pkg::SLOT_W'(frpq_pkg::SLOTS - 1))
                   ? '0 : r_wr_slot + frpq_pkg::SLOT_W'(1);

    // One RAM read per cycle until the whole frame has been read
    assign issue    = (r_state != S_IDLE) && (r_idx != r_len);
    assign seq_done = (r_idx == r_len) && r_p_vld;
    assign store_we = r_p_vld && (r_state == S_COPY);
    assign send_out = r_p_vld && (r_state == S_SEND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acnt    <= '0;
            r_rd_slot <= '0;
            r_wr_slot <= '0;
            r_count   <= '0;
            r_idx     <= '0;
            r_len     <= '0;
            r_p_vld   <= 1'b0;
            r_st_vld  <= 1'b0;
        end else begin
            r_st_vld <= 1'b0;
            r_p_vld  <= issue;
            if (issue) begin
                r_idx <= r_idx + frpq_pkg::IDX_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_opcode == frpq_pkg::OP_TICK)) begin
                        if (r_count != '0) begin
                            r_base    <= frpq_pkg::STORE_AW'(r_rd_slot)
                                       * frpq_pkg::STORE_AW'(frpq_pkg::SLOT_BYTES);
                            r_len     <= r_slot_len[r_rd_slot];
                            r_idx     <= '0;
                            r_rd_slot <= rd_next;
                            r_count   <= r_count - frpq_pkg::CNT_W'(1);
                            r_state   <= S_SEND;
                        end
                    end else if (accept) begin
                        if (r_acnt == frpq_pkg::ACNT_W'(0)) begin
                            if (i_rx_byte == frpq_pkg::SYNC0) begin
                                r_acnt <= frpq_pkg::ACNT_W'(1);
                            end
                        end else if (r_acnt == frpq_pkg::ACNT_W'(1)) begin
                            // resync: a fresh 0xAA restarts as the first byte
                            if (i_rx_byte == frpq_pkg::SYNC1) begin
                                r_acnt <= frpq_pkg::ACNT_W'(2);
                            end else if (i_rx_byte != frpq_pkg::SYNC0) begin
                                r_acnt <= '0;
                            end
                        end else begin
                            if (r_acnt == frpq_pkg::ACNT_W'(frpq_pkg::LEN_INDEX)) begin
                                r_len_byte <= i_rx_byte;
                            end
                            if (frame_done) begin
                                r_acnt   <= '0;
                                r_st_vld <= 1'b1;
                                if (r_count >= frpq_pkg::CNT_W'(frpq_pkg::SLOTS)) begin
                                    r_status <= frpq_pkg::ST_FULL;
                                end else if (n_acnt >
                                             frpq_pkg::ACNT_W'(frpq_pkg::SLOT_BYTES)) begin
                                    r_status <= frpq_pkg::ST_TOO_LONG;
                                end else begin
                                    r_status   <= frpq_pkg::ST_STORED;
                                    r_slot_len[r_wr_slot] <= frpq_pkg::IDX_W'(n_acnt);
                                    r_base     <= frpq_pkg::STORE_AW'(r_wr_slot)
                                                * frpq_pkg::STORE_AW'(frpq_pkg::SLOT_BYTES);
                                    r_len      <= frpq_pkg::IDX_W'(n_acnt);
                                    r_idx      <= '0;
                                    r_wr_slot  <= wr_next;
                                    r_count    <= r_count + frpq_pkg::CNT_W'(1);
                                    r_state    <= S_COPY;
                                end
                            end else begin
                                r_acnt <= n_acnt;
                            end
                        end
                    end
                end
                S_COPY, S_SEND: begin
                    if (seq_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload side of the read pipeline
    always_ff @(posedge i_clk) begin
        r_p_idx  <= r_idx;
        r_p_last <= (r_idx == r_len - frpq_pkg::IDX_W'(1));
    end

    // Assembly buffer: written as bytes arrive, read back during the copy.
    frpq_ram #(
        .WIDTH (8),
        .DEPTH (frpq_pkg::SLOT_BYTES)
    ) u_asm_ram (
        .i_clk   (i_clk),
        .i_we    (asm_we),
        .i_waddr (r_acnt[frpq_pkg::ASM_AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_idx[frpq_pkg::ASM_AW-1:0]),
        .o_rdata (asm_rdata)
    );

    // Frame store: written by the copy, read by the send. Busy keeps them apart.
    frpq_ram #(
        .WIDTH (8),
        .DEPTH (frpq_pkg::STORE_D)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_base + frpq_pkg::STORE_AW'(r_p_idx)),
        .i_wdata (asm_rdata),
        .i_raddr (r_base + frpq_pkg::STORE_AW'(r_idx)),
        .o_rdata (store_rdata)
    );

    // Result ports; the queue count is already up to date on either kind.
    assign o_valid         = r_st_vld || send_out;
    assign o_kind          = send_out ? frpq_pkg::KIND_BYTE : frpq_pkg::KIND_STATUS;
    assign o_status        = send_out ? 2'(frpq_pkg::ST_STORED) : 2'(r_status);
    assign o_tx_byte       = send_out ? store_rdata : 8'd0;
    assign o_last          = send_out ? r_p_last : 1'b1;
    assign o_frames_queued = 3'(r_count);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= frpq_pkg::CNT_W'(frpq_pkg::SLOTS))
        else $error("queue count above slot count");

    a_ring_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == '0) || (r_count == frpq_pkg::CNT_W'(frpq_pkg::SLOTS)))
            == (r_rd_slot == r_wr_slot))
        else $error("ring pointers disagree with queue count");

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st_vld && send_out))
        else $error("status and frame byte in the same cycle");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == frpq_pkg::OP_TICK) && (r_count != '0)) |=> o_busy)
        else $error("tick on a non-empty queue did not start a send");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (send_out && r_p_last) |=> (r_state == S_IDLE))
        else $error("send continued past the last byte");
`endif

endmodule

/* rtl/frpq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module frpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
